// ===== rtl/bucket_hash_partitioner_macros.svh =====
// assertion macros used by the checker
`ifndef BUCKET_HASH_PARTITIONER_MACROS_SVH
`define BUCKET_HASH_PARTITIONER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BHP_ASSERT_IMPLY(label, ck, rst, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define BHP_ASSERT_NEXT(label, ck, rst, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bhp_pkg.sv =====
`default_nettype none

package bhp_pkg;

  localparam int DEF_MAX_BUCKETS    = 1024;
  localparam int DEF_PARTITION_BITS = 12;

  localparam int OP_W          = 4;
  localparam int NUM_BUCKETS_W = 11;
  localparam int IN_TDATA_W    = 128;
  localparam int IN_TUSER_W    = 5;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int HASH_W        = 32;
  localparam int DIVIDEND_W    = 31;

  localparam logic [OP_W-1:0] OP_BOOL        = 4'd0;
  localparam logic [OP_W-1:0] OP_INT8        = 4'd1;
  localparam logic [OP_W-1:0] OP_INT16       = 4'd2;
  localparam logic [OP_W-1:0] OP_INT32       = 4'd3;
  localparam logic [OP_W-1:0] OP_REAL        = 4'd4;
  localparam logic [OP_W-1:0] OP_DOUBLE      = 4'd5;
  localparam logic [OP_W-1:0] OP_INT64       = 4'd6;
  localparam logic [OP_W-1:0] OP_TIMESTAMP   = 4'd7;
  localparam logic [OP_W-1:0] OP_DATE        = 4'd8;
  localparam logic [OP_W-1:0] OP_STRING      = 4'd9;
  localparam logic [OP_W-1:0] OP_HASH        = 4'd10;
  localparam logic [OP_W-1:0] OP_TABLE_WRITE = 4'd11;

  localparam logic REG_NUM_BUCKETS = 1'b0;

  typedef struct packed {
    logic        pad;
    logic [11:0] table_partition;
    logic [9:0]  table_index;
    logic        first_key;
    logic        string_last;
    logic        byte_valid;
    logic [7:0]  byte_value;
    logic [29:0] nanos;
    logic [63:0] value;
  } in_data_t;

  typedef struct packed {
    logic            is_null;
    logic [OP_W-1:0] op;
  } in_user_t;

endpackage

`default_nettype wire

// ===== rtl/bucket_hash_partitioner.sv =====
// bucket hash partitioner
// in channel: one key column per transaction (op and is_null in tuser, last key of
// the row in tlast, value, nanos, string byte, flags and table operands in tdata).
// op 11 loads one bucket table entry; the table holds garbage until loaded, so every
// bucket the configured count can reach must be written before rows are sent.
// out channel: one transaction per finished row, partition and bucket in tdata.
// cfg: apb register num_buckets at address 0, written while the block is idle; the
// user is bound to this, the block itself has no check for it. a table write leaves
// the sequencer idle; a column passes the row multiply and, but on a first key, the
// row add; a string byte passes the string multiply and add (plus the column steps
// on the string's last item). a row's last key adds the restoring divider for the
// bucket modulo, one table read and one output load. the arithmetic steps share the
// 32-bit adder/subtractor, one item at a time; in_tready is high only while idle.
// a result sits in the output register until taken; the next row's items are still
// accepted, and a second result waits after the table read until the register frees.
// reset: num_buckets 1, row and string hash 0, no result pending; table not cleared.
`default_nettype none

module bucket_hash_partitioner
  import bhp_pkg::*;
#(
  parameter int MAX_BUCKETS    = DEF_MAX_BUCKETS,
  parameter int PARTITION_BITS = DEF_PARTITION_BITS,
  localparam int BKT_W         = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
  localparam int OUT_FIELDS_W  = PARTITION_BITS + BKT_W,
  localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // value, nanos, byte_value, byte_valid, string_last, first_key, table_index,
  // table_partition, zero pad
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  // op, is_null
  input  wire logic [IN_TUSER_W-1:0] in_tuser,
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // partition, bucket, zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam int DIV_W = $clog2(MAX_BUCKETS + 1);
  localparam logic [4:0] DIV_TOP = 5'(DIVIDEND_W - 1);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_STR_MUL = 3'd1;
  localparam logic [2:0] ST_STR_ADD = 3'd2;
  localparam logic [2:0] ST_ROW_MUL = 3'd3;
  localparam logic [2:0] ST_ROW_ADD = 3'd4;
  localparam logic [2:0] ST_DIV     = 3'd5;
  localparam logic [2:0] ST_READ    = 3'd6;
  localparam logic [2:0] ST_OUT     = 3'd7;

  in_data_t in_d;
  in_user_t in_u;

  logic [2:0]               state_r, state_nxt;
  logic [NUM_BUCKETS_W-1:0] num_buckets_r, num_buckets_nxt;
  logic [HASH_W-1:0]        row_hash_r, row_hash_nxt;
  logic [HASH_W-1:0]        string_hash_r, string_hash_nxt;
  logic [4:0]               div_cnt_r, div_cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic [HASH_W-1:0]         col_r, col_nxt;
  logic [HASH_W-1:0]         byte_sx_r, byte_sx_nxt;
  logic                      first_key_r, first_key_nxt;
  logic                      last_key_r, last_key_nxt;
  logic                      is_null_r, is_null_nxt;
  logic                      str_last_r, str_last_nxt;
  logic [BKT_W-1:0]          rem_r, rem_nxt;
  logic [PARTITION_BITS-1:0] out_part_r, out_part_nxt;
  logic [BKT_W-1:0]          out_bkt_r, out_bkt_nxt;

  logic [HASH_W-1:0]         col_calc;
  logic [HASH_W-1:0]         alu_a, alu_b;
  logic                      alu_sub;
  logic [HASH_W:0]           alu_sum;
  logic [31:0]               div_sel;
  logic [DIV_W-1:0]          div_eff;
  logic [BKT_W:0]            div_shift;
  logic                      cfg_wr;

  logic                      ram_we, ram_re;
  logic [PARTITION_BITS-1:0] ram_rdata;

  assign in_d = in_data_t'(in_tdata);
  assign in_u = in_user_t'(in_tuser);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_bkt_r, out_part_r});

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[CFG_ADDR_W-1:2] == REG_NUM_BUCKETS);
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_NUM_BUCKETS) ?
                      CFG_DATA_W'(num_buckets_r) : '0;

  // shared adder / subtractor, carry out set means a >= b on subtract
  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {HASH_W{alu_sub}}} +
                   (HASH_W + 1)'(alu_sub);

  always_comb begin
    div_sel = 32'(num_buckets_r);
    if (div_sel == 32'd0) begin
      div_sel = 32'd1;
    end else if (div_sel > 32'(MAX_BUCKETS)) begin
      div_sel = 32'(MAX_BUCKETS);
    end
    div_eff = DIV_W'(div_sel);
  end

  assign div_shift = {rem_r, row_hash_r[div_cnt_r]};

  always_comb begin
    case (in_u.op) inside
      OP_BOOL:                             col_calc = {31'b0, |in_d.value};
      OP_INT8:                             col_calc = {{24{in_d.value[7]}},
                                                       in_d.value[7:0]};
      OP_INT16:                            col_calc = {{16{in_d.value[15]}},
                                                       in_d.value[15:0]};
      OP_INT32, OP_REAL, OP_DATE, OP_HASH: col_calc = in_d.value[31:0];
      OP_DOUBLE, OP_INT64:                 col_calc = in_d.value[63:32] ^
                                                      in_d.value[31:0];
      OP_TIMESTAMP:                        col_calc = in_d.value[33:2] ^
                                                      {in_d.value[1:0], in_d.nanos};
      OP_STRING:                           col_calc = string_hash_r;
      default:                             col_calc = '0;
    endcase
    if (in_u.is_null) begin
      col_calc = '0;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    num_buckets_nxt = cfg_wr ? cfg_pwdata[NUM_BUCKETS_W-1:0] : num_buckets_r;
    row_hash_nxt    = row_hash_r;
    string_hash_nxt = string_hash_r;
    div_cnt_nxt     = div_cnt_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    col_nxt         = col_r;
    byte_sx_nxt     = byte_sx_r;
    first_key_nxt   = first_key_r;
    last_key_nxt    = last_key_r;
    is_null_nxt     = is_null_r;
    str_last_nxt    = str_last_r;
    rem_nxt         = rem_r;
    out_part_nxt    = out_part_r;
    out_bkt_nxt     = out_bkt_r;
    alu_a           = row_hash_r;
    alu_b           = col_r;
    alu_sub         = 1'b0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          first_key_nxt = in_d.first_key;
          last_key_nxt  = in_tlast;
          is_null_nxt   = in_u.is_null;
          str_last_nxt  = in_d.string_last;
          byte_sx_nxt   = {{24{in_d.byte_value[7]}}, in_d.byte_value};
          col_nxt       = col_calc;
          case (in_u.op) inside
            OP_TABLE_WRITE: begin
              ram_we = (32'(in_d.table_index) < 32'(MAX_BUCKETS));
            end
            OP_STRING: begin
              if (in_d.byte_valid) begin
                state_nxt = ST_STR_MUL;
              end else if (in_d.string_last) begin
                string_hash_nxt = '0;
                state_nxt       = ST_ROW_MUL;
              end
            end
            [OP_BOOL:OP_DATE], OP_HASH: begin
              state_nxt = ST_ROW_MUL;
            end
            default: ;
          endcase
        end
      end
      ST_STR_MUL: begin
        alu_a           = string_hash_r << 5;
        alu_b           = string_hash_r;
        alu_sub         = 1'b1;
        string_hash_nxt = alu_sum[HASH_W-1:0];
        state_nxt       = ST_STR_ADD;
      end
      ST_STR_ADD: begin
        alu_a = string_hash_r;
        alu_b = byte_sx_r;
        if (str_last_r) begin
          col_nxt         = is_null_r ? '0 : alu_sum[HASH_W-1:0];
          string_hash_nxt = '0;
          state_nxt       = ST_ROW_MUL;
        end else begin
          string_hash_nxt = alu_sum[HASH_W-1:0];
          state_nxt       = ST_IDLE;
        end
      end
      ST_ROW_MUL: begin
        alu_a   = row_hash_r << 5;
        alu_b   = row_hash_r;
        alu_sub = 1'b1;
        if (first_key_r) begin
          row_hash_nxt = col_r;
          rem_nxt      = '0;
          div_cnt_nxt  = DIV_TOP;
          state_nxt    = last_key_r ? ST_DIV : ST_IDLE;
        end else begin
          row_hash_nxt = alu_sum[HASH_W-1:0];
          state_nxt    = ST_ROW_ADD;
        end
      end
      ST_ROW_ADD: begin
        row_hash_nxt = alu_sum[HASH_W-1:0];
        rem_nxt      = '0;
        div_cnt_nxt  = DIV_TOP;
        state_nxt    = last_key_r ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        alu_a   = HASH_W'(div_shift);
        alu_b   = HASH_W'(div_eff);
        alu_sub = 1'b1;
        rem_nxt = alu_sum[HASH_W] ? alu_sum[BKT_W-1:0] : div_shift[BKT_W-1:0];
        if (div_cnt_r == 5'd0) begin
          state_nxt = ST_READ;
        end else begin
          div_cnt_nxt = div_cnt_r - 5'd1;
        end
      end
      ST_READ: begin
        ram_re    = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_part_nxt  = ram_rdata;
          out_bkt_nxt   = rem_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      num_buckets_r <= NUM_BUCKETS_W'(1);
      row_hash_r    <= '0;
      string_hash_r <= '0;
      div_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      num_buckets_r <= num_buckets_nxt;
      row_hash_r    <= row_hash_nxt;
      string_hash_r <= string_hash_nxt;
      div_cnt_r     <= div_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r       <= col_nxt;
    byte_sx_r   <= byte_sx_nxt;
    first_key_r <= first_key_nxt;
    last_key_r  <= last_key_nxt;
    is_null_r   <= is_null_nxt;
    str_last_r  <= str_last_nxt;
    rem_r       <= rem_nxt;
    out_part_r  <= out_part_nxt;
    out_bkt_r   <= out_bkt_nxt;
  end

  bhp_ram #(
    .WIDTH (PARTITION_BITS),
    .DEPTH (MAX_BUCKETS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (BKT_W'(in_d.table_index)),
    .wdata (PARTITION_BITS'(in_d.table_partition)),
    .re    (ram_re),
    .raddr (rem_r),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/bhp_ram.sv =====
`default_nettype none

module bhp_ram
  import bhp_pkg::*;
#(
  parameter int WIDTH = DEF_PARTITION_BITS,
  parameter int DEPTH = DEF_MAX_BUCKETS,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/bhp_checker.sv =====
`default_nettype none
`include "bucket_hash_partitioner_macros.svh"

module bhp_checker
  import bhp_pkg::*;
#(
  parameter int OUT_DATA_W = 24
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [IN_TUSER_W-1:0] in_tuser,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  logic in_acc;
  logic [OP_W-1:0] in_op;

  assign in_acc = in_tvalid && in_tready;
  assign in_op  = in_tuser[OP_W-1:0];

  // a stalled result holds
  `BHP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // a typed column leaves the sequencer busy once it is accepted
  `BHP_ASSERT_NEXT(a_col_busy, clk, rst_n, in_acc && (in_op <= OP_DATE || in_op == OP_HASH), !in_tready, "ready right after a column")

  // a table write finishes in its own cycle
  `BHP_ASSERT_NEXT(a_tw_single, clk, rst_n, in_acc && in_op == OP_TABLE_WRITE, in_tready, "busy after a table write")

  // a result is only produced from a busy sequencer
  `BHP_ASSERT_IMPLY(a_out_busy, clk, rst_n, $rose(out_tvalid), !$past(in_tready), "result appeared while idle")

endmodule

bind bucket_hash_partitioner bhp_checker #(
  .OUT_DATA_W (OUT_DATA_W)
) u_bhp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
